### rtl/vn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vn_pkg: shared types and constants of the vector normalize unit
// Holds the request and response payload types and the fixed field widths.
// ----------------------------------------------------------------------------
package vn_pkg;

   // Width of one vector component; used by the payload structs.
   localparam int COMP_W = 24;

   // Default number of fractional bits of a unit component.
   localparam int FRAC_BITS_DEFAULT = 22;

   typedef struct packed {
      logic signed [COMP_W-1:0] comp_x;
      logic signed [COMP_W-1:0] comp_y;
      logic signed [COMP_W-1:0] comp_z;
   } vn_req_type;

   typedef struct packed {
      logic signed [COMP_W-1:0] unit_x;
      logic signed [COMP_W-1:0] unit_y;
      logic signed [COMP_W-1:0] unit_z;
      logic                     zero_length;
   } vn_rsp_type;

endpackage

### rtl/vector3_normalize_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector3_normalize_unit: streaming 3D vector normalization
// Scales a vector of signed fixed-point components to unit length, giving
// Q1.FRACTION_BITS components truncated toward zero, one vector per clock unless stalled.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake              Payload
//   req_      in         req_valid / req_ready  vn_req_type (comp_x/y/z)
//   rsp_      out        rsp_valid / rsp_ready  vn_rsp_type (unit_x/y/z, zero_length)
//
// One item enters per clock unless the response stalls; a result passes
// one magnitude stage, FRACTION_BITS + 1 cells and one output stage.
// The search runs in the row of cells, each of which settles one bit of
// the unit magnitudes of all three components.
// Reset is synchronous and active high; it empties every stage.
// Each stage holds its item until the next one frees up, so a stalled
// response fills the row from the end while earlier stages keep accepting.
//
// The search keeps, per component, the residual mag^2*2^(2F) - q^2*S and the
// product q*S, so each cell only shifts, adds and compares. For a zero vector
// the output stage forces the components to zero and sets zero_length.
// ----------------------------------------------------------------------------
module vector3_normalize_unit
   import vn_pkg::*;
#(
   parameter int FRACTION_BITS = FRAC_BITS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  vn_req_type req_data,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output vn_rsp_type rsp_data
);

   localparam int SW     = 2*COMP_W + 2;
   localparam int WW     = 2*COMP_W + 2*FRACTION_BITS + 4;
   localparam int QW     = FRACTION_BITS + 1;
   localparam int NCELLS = FRACTION_BITS + 1;

   // Link k feeds cell k; link NCELLS feeds the output stage.
   logic               lnk_valid [NCELLS+1];
   logic               lnk_ready [NCELLS+1];
   logic [SW-1:0]      lnk_sum   [NCELLS+1];
   logic [2:0][WW-1:0] lnk_rem   [NCELLS+1];
   logic [2:0][WW-1:0] lnk_prod  [NCELLS+1];
   logic [2:0][QW-1:0] lnk_q     [NCELLS+1];
   logic [2:0]         lnk_neg   [NCELLS+1];
   logic               lnk_zero  [NCELLS+1];

   vn_front #(
      .FRACTION_BITS(FRACTION_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (req_data),
      .out_valid (lnk_valid[0]),
      .out_ready (lnk_ready[0]),
      .out_sum   (lnk_sum[0]),
      .out_rem   (lnk_rem[0]),
      .out_neg   (lnk_neg[0]),
      .out_zero  (lnk_zero[0])
   );

   // The search starts from q = 0, so q*S starts at zero too.
   assign lnk_prod[0] = '0;
   assign lnk_q[0]    = '0;

   // Cells run from the top bit of q down to bit zero.
   for (genvar g = 0; g < NCELLS; g++) begin : g_cell
      vn_cell #(
         .FRACTION_BITS(FRACTION_BITS),
         .BIT_POS      (FRACTION_BITS - g)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (lnk_valid[g]),
         .in_ready  (lnk_ready[g]),
         .in_sum    (lnk_sum[g]),
         .in_rem    (lnk_rem[g]),
         .in_prod   (lnk_prod[g]),
         .in_q      (lnk_q[g]),
         .in_neg    (lnk_neg[g]),
         .in_zero   (lnk_zero[g]),
         .out_valid (lnk_valid[g+1]),
         .out_ready (lnk_ready[g+1]),
         .out_sum   (lnk_sum[g+1]),
         .out_rem   (lnk_rem[g+1]),
         .out_prod  (lnk_prod[g+1]),
         .out_q     (lnk_q[g+1]),
         .out_neg   (lnk_neg[g+1]),
         .out_zero  (lnk_zero[g+1])
      );
   end

   vn_out #(
      .FRACTION_BITS(FRACTION_BITS)
   ) u_out (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (lnk_valid[NCELLS]),
      .in_ready  (lnk_ready[NCELLS]),
      .in_q      (lnk_q[NCELLS]),
      .in_neg    (lnk_neg[NCELLS]),
      .in_zero   (lnk_zero[NCELLS]),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_data)
   );

   // Largest unit magnitude, 1.0 in Q1.F, widened for signed compares.
   localparam logic signed [32:0] ONE_POS = 33'sd1 <<< FRACTION_BITS;
   localparam logic signed [32:0] ONE_NEG = -ONE_POS;

   // A zero vector must come out as all-zero components.
   a_zero_out : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.zero_length |->
         rsp_data.unit_x == '0 && rsp_data.unit_y == '0 && rsp_data.unit_z == '0)
      else $error("zero vector item has nonzero components");

   // No unit component exceeds one in magnitude.
   a_unit_bound : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         33'(rsp_data.unit_x) <= ONE_POS && 33'(rsp_data.unit_x) >= ONE_NEG &&
         33'(rsp_data.unit_y) <= ONE_POS && 33'(rsp_data.unit_y) >= ONE_NEG &&
         33'(rsp_data.unit_z) <= ONE_POS && 33'(rsp_data.unit_z) >= ONE_NEG)
      else $error("unit component beyond one");

   // The input can only stall when a finished item waits at the output.
   a_stall_cause : assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input stalled without output backpressure");

   // A waiting result is not replaced before it is taken.
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("pending result changed");

endmodule

### rtl/vn_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vn_front: magnitude and squared-length stage
// Splits each component into sign and magnitude, squares the magnitudes and
// registers the squared length together with the starting residuals.
// ----------------------------------------------------------------------------
module vn_front
   import vn_pkg::*;
#(
   parameter int FRACTION_BITS = FRAC_BITS_DEFAULT
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      in_valid,
   output logic                                      in_ready,
   input  vn_req_type                                in_data,
   output logic                                      out_valid,
   input  logic                                      out_ready,
   output logic [2*COMP_W+1:0]                       out_sum,
   output logic [2:0][2*COMP_W+2*FRACTION_BITS+3:0]  out_rem,
   output logic [2:0]                                out_neg,
   output logic                                      out_zero
);

   localparam int SW = 2*COMP_W + 2;
   localparam int WW = 2*COMP_W + 2*FRACTION_BITS + 4;

   logic [2:0][COMP_W-1:0]   comp;
   logic [2:0][COMP_W-1:0]   mag;
   logic [2:0][2*COMP_W-1:0] sq;
   logic [SW-1:0]            sum;

   logic                     valid_ff, valid_in;
   logic [SW-1:0]            sum_ff;
   logic [2:0][WW-1:0]       rem_ff, rem_in;
   logic [2:0]               neg_ff, neg_in;
   logic                     zero_ff;

   assign comp[0] = in_data.comp_x;
   assign comp[1] = in_data.comp_y;
   assign comp[2] = in_data.comp_z;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         neg_in[i] = comp[i][COMP_W-1];
         mag[i]    = neg_in[i] ? (~comp[i] + 1'b1) : comp[i];
         sq[i]     = mag[i] * mag[i];
         rem_in[i] = WW'(sq[i]) << (2*FRACTION_BITS);
      end
      sum = SW'(sq[0]) + SW'(sq[1]) + SW'(sq[2]);
   end

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         sum_ff  <= sum;
         rem_ff  <= rem_in;
         neg_ff  <= neg_in;
         zero_ff <= (sum == '0);
      end
   end

   assign out_valid = valid_ff;
   assign out_sum   = sum_ff;
   assign out_rem   = rem_ff;
   assign out_neg   = neg_ff;
   assign out_zero  = zero_ff;

endmodule

### rtl/vn_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vn_cell: one quotient bit of the unit search
// Tries to set bit BIT_POS of q for all three components. The residual
// rem = mag^2*2^(2F) - q^2*S and the running product qs = q*S are kept, so
// the trial (q+2^b)^2*S - q^2*S needs only shifts and adds.
// ----------------------------------------------------------------------------
module vn_cell
   import vn_pkg::*;
#(
   parameter int FRACTION_BITS = FRAC_BITS_DEFAULT,
   parameter int BIT_POS       = 0
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      in_valid,
   output logic                                      in_ready,
   input  logic [2*COMP_W+1:0]                       in_sum,
   input  logic [2:0][2*COMP_W+2*FRACTION_BITS+3:0]  in_rem,
   input  logic [2:0][2*COMP_W+2*FRACTION_BITS+3:0]  in_prod,
   input  logic [2:0][FRACTION_BITS:0]               in_q,
   input  logic [2:0]                                in_neg,
   input  logic                                      in_zero,
   output logic                                      out_valid,
   input  logic                                      out_ready,
   output logic [2*COMP_W+1:0]                       out_sum,
   output logic [2:0][2*COMP_W+2*FRACTION_BITS+3:0]  out_rem,
   output logic [2:0][2*COMP_W+2*FRACTION_BITS+3:0]  out_prod,
   output logic [2:0][FRACTION_BITS:0]               out_q,
   output logic [2:0]                                out_neg,
   output logic                                      out_zero
);

   localparam int SW = 2*COMP_W + 2;
   localparam int WW = 2*COMP_W + 2*FRACTION_BITS + 4;
   localparam int QW = FRACTION_BITS + 1;

   logic [WW-1:0]         sum_wide;
   logic [2:0][WW-1:0]    trial;
   logic [2:0][WW-1:0]    rem_in, prod_in;
   logic [2:0][QW-1:0]    q_in;

   logic                  valid_ff, valid_in;
   logic [SW-1:0]         sum_ff;
   logic [2:0][WW-1:0]    rem_ff, prod_ff;
   logic [2:0][QW-1:0]    q_ff;
   logic [2:0]            neg_ff;
   logic                  zero_ff;

   assign sum_wide = WW'(in_sum);

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         trial[i] = (in_prod[i] << (BIT_POS + 1)) + (sum_wide << (2*BIT_POS));
         if (trial[i] <= in_rem[i]) begin
            rem_in[i]  = in_rem[i] - trial[i];
            prod_in[i] = in_prod[i] + (sum_wide << BIT_POS);
            q_in[i]    = in_q[i] | (QW'(1) << BIT_POS);
         end else begin
            rem_in[i]  = in_rem[i];
            prod_in[i] = in_prod[i];
            q_in[i]    = in_q[i];
         end
      end
   end

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         sum_ff  <= in_sum;
         rem_ff  <= rem_in;
         prod_ff <= prod_in;
         q_ff    <= q_in;
         neg_ff  <= in_neg;
         zero_ff <= in_zero;
      end
   end

   assign out_valid = valid_ff;
   assign out_sum   = sum_ff;
   assign out_rem   = rem_ff;
   assign out_prod  = prod_ff;
   assign out_q     = q_ff;
   assign out_neg   = neg_ff;
   assign out_zero  = zero_ff;

endmodule

### rtl/vn_out.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vn_out: sign, saturation and output register
// Applies the component signs to the unit magnitudes, clamps them to the
// component range and holds the finished item for the response channel.
// ----------------------------------------------------------------------------
module vn_out
   import vn_pkg::*;
#(
   parameter int FRACTION_BITS = FRAC_BITS_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  logic [2:0][FRACTION_BITS:0] in_q,
   input  logic [2:0]                  in_neg,
   input  logic                        in_zero,
   output logic                        out_valid,
   input  logic                        out_ready,
   output vn_rsp_type                  out_data
);

   localparam int QW = FRACTION_BITS + 1;
   localparam int XW = ((QW > COMP_W) ? QW : COMP_W) + 1;
   localparam logic [XW-1:0] LIM_POS = (XW'(1) << (COMP_W - 1)) - XW'(1);
   localparam logic [XW-1:0] LIM_NEG = XW'(1) << (COMP_W - 1);

   logic [2:0][XW-1:0]     qx, clip;
   logic [2:0][COMP_W-1:0] unit;
   logic                   valid_ff, valid_in;
   vn_rsp_type             data_ff, data_in;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         qx[i] = XW'(in_q[i]);
         if (in_neg[i]) begin
            clip[i] = (qx[i] > LIM_NEG) ? LIM_NEG : qx[i];
            clip[i] = ~clip[i] + 1'b1;
         end else begin
            clip[i] = (qx[i] > LIM_POS) ? LIM_POS : qx[i];
         end
         unit[i] = in_zero ? '0 : clip[i][COMP_W-1:0];
      end
      data_in.unit_x      = unit[0];
      data_in.unit_y      = unit[1];
      data_in.unit_z      = unit[2];
      data_in.zero_length = in_zero;
   end

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule
